// File: src/energy_voice_activity_gate_core_assert.svh
// Assertion macros shared by the energy voice activity gate RTL
`ifndef ENERGY_VOICE_ACTIVITY_GATE_CORE_ASSERT_SVH
`define ENERGY_VOICE_ACTIVITY_GATE_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low
`define EVA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low
`define EVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/eva_pkg.sv
// Types and constants of the energy voice activity gate
package eva_pkg;

  // Sample and energy widths
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned DEV_W       = 8;
  localparam int unsigned LEN_W       = 12;
  localparam int unsigned ACC_W       = 20;
  localparam int unsigned ENERGY_W    = 19;
  localparam int unsigned UPPER_W     = 22;
  localparam int unsigned CAL_SUM_W   = 23;
  localparam int unsigned CAL_CNT_W   = 4;
  localparam int unsigned SPAN_W      = 22;
  localparam int unsigned PROD_W      = 46;

  localparam logic [SAMPLE_W-1:0] ZERO_LEVEL       = 8'd127;
  localparam logic [LEN_W-1:0]    MIN_FRAME_LENGTH = 12'd2;
  localparam logic [LEN_W-1:0]    MAX_FRAME_LENGTH = 12'd4095;
  localparam logic [LEN_W-1:0]    FRAME_LENGTH_RST = 12'd160;

  // Calibration: frame count and fixed-point reciprocals for mean and percent
  localparam int unsigned CAL_FRAMES = 10;
  localparam logic [CAL_CNT_W-1:0] CAL_COUNT_DONE = 4'(CAL_FRAMES);
  localparam logic [CAL_CNT_W-1:0] CAL_COUNT_LAST = 4'(CAL_FRAMES - 1);
  localparam int unsigned MEAN_SHIFT = 26;
  localparam logic [22:0] MEAN_RECIP = 23'((64'd1 << MEAN_SHIFT) / CAL_FRAMES);
  localparam int unsigned MEAN_Q_W   = 23;
  localparam int unsigned PCT_SHIFT  = 29;
  localparam int unsigned PCT_DIV    = 100;
  localparam logic [22:0] PCT_RECIP  = 23'((64'd1 << PCT_SHIFT) / PCT_DIV);
  localparam int unsigned PCT_Q_W    = 17;
  localparam int unsigned SPAN_MUL   = 3;
  localparam int unsigned UPPER_MUL  = 5;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_FRAME_LENGTH  = 1'b0;
  localparam logic REG_DETECT_ENABLE = 1'b1;

  // Frame queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;

  // Completed frame handed from front to queue
  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] energy;
  } frame_push_t;

  // Back sequencer
  typedef enum logic [2:0] {
    BK_RUN,
    BK_MEAN_MUL,
    BK_MEAN_FIX,
    BK_SPAN,
    BK_PCT_MUL,
    BK_PCT_FIX,
    BK_EMIT
  } back_state_e;

endpackage

// File: src/energy_voice_activity_gate_core.sv
// Throughput: one sample per cycle; the front stalls only while the frame queue is full.
// A frame's energy enters the frame queue when its last sample is taken; its result is
// registered when the back sequencer pops it. The last calibration frame first goes through
// the two reciprocal multiplies with correction in the back sequencer, then the upper threshold.
// Reset clears accumulators, calibration, thresholds and speech flag; frame_length
// resets to 160 and detect_enable to 1.
module energy_voice_activity_gate_core import eva_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic                  sample_valid_i,
  output logic                  sample_ready_o,
  output logic                  result_valid_o,
  input  logic                  result_ready_i,
  output logic [ENERGY_W-1:0]   frame_energy_o,
  output logic                  forward_o,
  output logic                  speech_active_o,
  output logic                  calibrating_o,
  output logic [ENERGY_W-1:0]   lower_threshold_o,
  output logic [UPPER_W-1:0]    upper_threshold_o
);

`include "energy_voice_activity_gate_core_assert.svh"

  logic [LEN_W-1:0] frame_length_q, frame_length_d;
  logic             detect_enable_q, detect_enable_d;
  logic             cfg_write;
  frame_push_t      push;
  logic             queue_full;
  logic             frame_valid;
  logic [ACC_W-1:0] frame_energy;
  logic             frame_pop;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    frame_length_d  = frame_length_q;
    detect_enable_d = detect_enable_q;
    if (cfg_write) begin
      unique case (paddr[2])
        REG_FRAME_LENGTH:  frame_length_d  = pwdata[LEN_W-1:0];
        REG_DETECT_ENABLE: detect_enable_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_LENGTH:  prdata = APB_DATA_W'(frame_length_q);
      REG_DETECT_ENABLE: prdata = APB_DATA_W'(detect_enable_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q  <= FRAME_LENGTH_RST;
      detect_enable_q <= 1'b1;
    end else begin
      frame_length_q  <= frame_length_d;
      detect_enable_q <= detect_enable_d;
    end
  end

  eva_sample_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .frame_length_i (frame_length_q),
    .queue_full_i   (queue_full),
    .push_o         (push)
  );

  eva_frame_queue u_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (queue_full),
    .frame_valid_o  (frame_valid),
    .frame_energy_o (frame_energy),
    .pop_i          (frame_pop)
  );

  eva_frame_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .frame_valid_i     (frame_valid),
    .frame_energy_i    (frame_energy),
    .frame_pop_o       (frame_pop),
    .detect_enable_i   (detect_enable_q),
    .result_valid_o    (result_valid_o),
    .result_ready_i    (result_ready_i),
    .frame_energy_o    (frame_energy_o),
    .forward_o         (forward_o),
    .speech_active_o   (speech_active_o),
    .calibrating_o     (calibrating_o),
    .lower_threshold_o (lower_threshold_o),
    .upper_threshold_o (upper_threshold_o)
  );

  // Checks on queue flow and result consistency
  `EVA_ASSERT_IMPLY(a_no_push_when_full, push.valid, !queue_full, "frame pushed into full queue")
  `EVA_ASSERT_IMPLY(a_cal_not_forwarded, result_valid_o && calibrating_o, !forward_o, "calibration frame forwarded")
  `EVA_ASSERT_IMPLY(a_upper_is_five_lower, result_valid_o && !calibrating_o, upper_threshold_o == (UPPER_W'(lower_threshold_o) * UPPER_W'(UPPER_MUL)), "upper threshold is not five times lower")
  `EVA_ASSERT_NEXT(a_pop_frees_space, frame_pop && queue_full && !push.valid, !queue_full, "queue stayed full after pop")

endmodule

// File: src/eva_sample_front.sv
// Front end: per-sample deviation accumulation and frame boundary detection
module eva_sample_front import eva_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                sample_valid_i,
  output logic                sample_ready_o,
  input  logic [LEN_W-1:0]    frame_length_i,
  input  logic                queue_full_i,
  output frame_push_t         push_o
);

  logic [ACC_W-1:0] acc_q, acc_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [DEV_W-1:0] dev;
  logic [ACC_W-1:0] acc_sum;
  logic [LEN_W-1:0] cnt_inc;
  logic [LEN_W-1:0] eff_len;
  logic             accept;
  logic             frame_done;

  // Clamp the frame length into its legal range
  always_comb begin
    if (frame_length_i < MIN_FRAME_LENGTH) begin
      eff_len = MIN_FRAME_LENGTH;
    end else if (frame_length_i > MAX_FRAME_LENGTH) begin
      eff_len = MAX_FRAME_LENGTH;
    end else begin
      eff_len = frame_length_i;
    end
  end

  // Accumulate the deviation and close the frame at the length
  always_comb begin
    dev        = (sample_i >= ZERO_LEVEL) ? (sample_i - ZERO_LEVEL) : (ZERO_LEVEL - sample_i);
    acc_sum    = acc_q + ACC_W'(dev);
    cnt_inc    = cnt_q + LEN_W'(1);
    frame_done = (cnt_inc >= eff_len);
    accept     = sample_valid_i && !queue_full_i;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    if (accept) begin
      if (frame_done) begin
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = acc_sum;
        cnt_d = cnt_inc;
      end
    end
  end

  assign sample_ready_o = !queue_full_i;
  assign push_o.valid   = accept && frame_done;
  assign push_o.energy  = acc_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: src/eva_frame_queue.sv
// Two-entry queue of frame energies between front and back
module eva_frame_queue import eva_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  frame_push_t      push_i,
  output logic             full_o,
  output logic             frame_valid_o,
  output logic [ACC_W-1:0] frame_energy_o,
  input  logic             pop_i
);

  logic [ACC_W-1:0]       entry_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_PTR_W:0]   count_q, count_d;
  logic                   do_push;
  logic                   do_pop;

  assign full_o         = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign frame_valid_o  = (count_q != '0);
  assign frame_energy_o = entry_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    do_push  = push_i.valid && !full_o;
    do_pop   = pop_i && frame_valid_o;
    wr_ptr_d = do_push ? wr_ptr_q + QUEUE_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QUEUE_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + (QUEUE_PTR_W+1)'(do_push) - (QUEUE_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed energy
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.energy;
    end
  end

endmodule

// File: src/eva_frame_back.sv
// Back end: calibration, threshold computation, hysteresis and result register
module eva_frame_back import eva_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                frame_valid_i,
  input  logic [ACC_W-1:0]    frame_energy_i,
  output logic                frame_pop_o,
  input  logic                detect_enable_i,
  output logic                result_valid_o,
  input  logic                result_ready_i,
  output logic [ENERGY_W-1:0] frame_energy_o,
  output logic                forward_o,
  output logic                speech_active_o,
  output logic                calibrating_o,
  output logic [ENERGY_W-1:0] lower_threshold_o,
  output logic [UPPER_W-1:0]  upper_threshold_o
);

  back_state_e state_q, state_d;

  logic [CAL_CNT_W-1:0] cal_cnt_q, cal_cnt_d;
  logic [ACC_W-1:0]     peak_q, peak_d;
  logic [CAL_SUM_W-1:0] cal_sum_q, cal_sum_d;
  logic [ACC_W-1:0]     lower_q, lower_d;
  logic [UPPER_W-1:0]   upper_q, upper_d;
  logic                 speech_q, speech_d;
  logic [ACC_W-1:0]     held_q, held_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [MEAN_Q_W-1:0]  imn_q, imn_d;
  logic [SPAN_W-1:0]    span_q, span_d;

  logic                 res_valid_q, res_valid_d;
  logic [ENERGY_W-1:0]  res_energy_q, res_energy_d;
  logic                 res_fwd_q, res_fwd_d;
  logic                 res_speech_q, res_speech_d;
  logic                 res_cal_q, res_cal_d;
  logic [ENERGY_W-1:0]  res_lower_q, res_lower_d;
  logic [UPPER_W-1:0]   res_upper_q, res_upper_d;

  logic                 out_free;
  logic                 pop;
  logic                 in_cal;
  logic                 last_cal;
  logic [MEAN_Q_W-1:0]  mean_q0;
  logic [CAL_SUM_W-1:0] mean_rem;
  logic [ACC_W-1:0]     span_diff;
  logic [PCT_Q_W-1:0]   pct_q0;
  logic [SPAN_W-1:0]    pct_rem;
  logic [PCT_Q_W-1:0]   pct_q;
  logic [MEAN_Q_W+1:0]  low_a;
  logic [MEAN_Q_W+1:0]  low_b;
  logic [UPPER_W-1:0]   upper_new;

  assign out_free    = !res_valid_q || result_ready_i;
  assign in_cal      = (cal_cnt_q < CAL_COUNT_DONE);
  assign last_cal    = (cal_cnt_q == CAL_COUNT_LAST);
  assign pop         = (state_q == BK_RUN) && frame_valid_i && out_free;
  assign frame_pop_o = pop;

  // Next state of the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_RUN: begin
        if (pop && in_cal && last_cal) begin
          state_d = BK_MEAN_MUL;
        end
      end
      BK_MEAN_MUL: state_d = BK_MEAN_FIX;
      BK_MEAN_FIX: state_d = BK_SPAN;
      BK_SPAN:     state_d = BK_PCT_MUL;
      BK_PCT_MUL:  state_d = BK_PCT_FIX;
      BK_PCT_FIX:  state_d = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          state_d = BK_RUN;
        end
      end
      default:     state_d = BK_RUN;
    endcase
  end

  // Threshold arithmetic terms
  always_comb begin
    mean_q0   = prod_q[MEAN_SHIFT +: MEAN_Q_W];
    mean_rem  = cal_sum_q - CAL_SUM_W'(mean_q0 * MEAN_Q_W'(CAL_FRAMES));
    span_diff = (ACC_W'(imn_q) <= peak_q && imn_q[MEAN_Q_W-1:ACC_W] == '0)
                ? (peak_q - ACC_W'(imn_q)) : '0;
    pct_q0    = prod_q[PCT_SHIFT +: PCT_Q_W];
    pct_rem   = span_q - SPAN_W'(pct_q0) * SPAN_W'(PCT_DIV);
    pct_q     = (pct_rem >= SPAN_W'(PCT_DIV)) ? pct_q0 + PCT_Q_W'(1) : pct_q0;
    low_a     = (MEAN_Q_W+2)'(imn_q) + (MEAN_Q_W+2)'(pct_q);
    low_b     = (MEAN_Q_W+2)'(imn_q) << 2;
    upper_new = UPPER_W'(lower_q * UPPER_W'(UPPER_MUL));
  end

  // Datapath and result register loads
  always_comb begin
    cal_cnt_d    = cal_cnt_q;
    peak_d       = peak_q;
    cal_sum_d    = cal_sum_q;
    lower_d      = lower_q;
    upper_d      = upper_q;
    speech_d     = speech_q;
    held_d       = held_q;
    prod_d       = prod_q;
    imn_d        = imn_q;
    span_d       = span_q;
    res_valid_d  = res_valid_q && !result_ready_i;
    res_energy_d = res_energy_q;
    res_fwd_d    = res_fwd_q;
    res_speech_d = res_speech_q;
    res_cal_d    = res_cal_q;
    res_lower_d  = res_lower_q;
    res_upper_d  = res_upper_q;
    unique case (state_q)
      BK_RUN: begin
        if (pop) begin
          if (in_cal) begin
            // Track peak and sum of the calibration frames
            if (cal_cnt_q == '0 || frame_energy_i > peak_q) begin
              peak_d = frame_energy_i;
            end
            cal_sum_d = cal_sum_q + CAL_SUM_W'(frame_energy_i);
            cal_cnt_d = cal_cnt_q + CAL_CNT_W'(1);
            held_d    = frame_energy_i;
            if (!last_cal) begin
              res_valid_d  = 1'b1;
              res_energy_d = frame_energy_i[ENERGY_W-1:0];
              res_fwd_d    = 1'b0;
              res_speech_d = speech_q;
              res_cal_d    = 1'b1;
              res_lower_d  = lower_q[ENERGY_W-1:0];
              res_upper_d  = upper_q;
            end
          end else begin
            // Apply hysteresis, or pass everything when detection is off
            res_fwd_d = 1'b0;
            if (!detect_enable_i) begin
              res_fwd_d = 1'b1;
            end else if (UPPER_W'(frame_energy_i) > upper_q ||
                         (frame_energy_i > lower_q && speech_q)) begin
              speech_d  = 1'b1;
              res_fwd_d = 1'b1;
            end else if (frame_energy_i < lower_q && speech_q) begin
              speech_d  = 1'b0;
              res_fwd_d = 1'b1;
            end
            res_valid_d  = 1'b1;
            res_energy_d = frame_energy_i[ENERGY_W-1:0];
            res_speech_d = speech_d;
            res_cal_d    = 1'b0;
            res_lower_d  = lower_q[ENERGY_W-1:0];
            res_upper_d  = upper_q;
          end
        end
      end
      BK_MEAN_MUL: prod_d = PROD_W'(cal_sum_q * PROD_W'(MEAN_RECIP));
      BK_MEAN_FIX: begin
        imn_d = (mean_rem >= CAL_SUM_W'(CAL_FRAMES)) ? mean_q0 + MEAN_Q_W'(1) : mean_q0;
      end
      BK_SPAN:     span_d = SPAN_W'(span_diff * SPAN_W'(SPAN_MUL));
      BK_PCT_MUL:  prod_d = PROD_W'(span_q * PROD_W'(PCT_RECIP));
      BK_PCT_FIX: begin
        lower_d = (low_a < low_b) ? low_a[ACC_W-1:0] : low_b[ACC_W-1:0];
      end
      BK_EMIT: begin
        // Publish the last calibration frame with the new thresholds
        upper_d = upper_new;
        if (out_free) begin
          res_valid_d  = 1'b1;
          res_energy_d = held_q[ENERGY_W-1:0];
          res_fwd_d    = 1'b0;
          res_speech_d = speech_q;
          res_cal_d    = 1'b1;
          res_lower_d  = lower_q[ENERGY_W-1:0];
          res_upper_d  = upper_new;
        end
      end
      default: ;
    endcase
  end

  // Control and detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      cal_cnt_q   <= '0;
      peak_q      <= '0;
      cal_sum_q   <= '0;
      lower_q     <= '0;
      upper_q     <= '0;
      speech_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cal_cnt_q   <= cal_cnt_d;
      peak_q      <= peak_d;
      cal_sum_q   <= cal_sum_d;
      lower_q     <= lower_d;
      upper_q     <= upper_d;
      speech_q    <= speech_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload and scratch registers
  always_ff @(posedge clk_i) begin
    held_q       <= held_d;
    prod_q       <= prod_d;
    imn_q        <= imn_d;
    span_q       <= span_d;
    res_energy_q <= res_energy_d;
    res_fwd_q    <= res_fwd_d;
    res_speech_q <= res_speech_d;
    res_cal_q    <= res_cal_d;
    res_lower_q  <= res_lower_d;
    res_upper_q  <= res_upper_d;
  end

  assign result_valid_o    = res_valid_q;
  assign frame_energy_o    = res_energy_q;
  assign forward_o         = res_fwd_q;
  assign speech_active_o   = res_speech_q;
  assign calibrating_o     = res_cal_q;
  assign lower_threshold_o = res_lower_q;
  assign upper_threshold_o = res_upper_q;

endmodule
